// File: rtl/pfasm_pkg.sv
// ----------------------------------------------------------------------------
// pfasm_pkg
// Types and constants for the secp256k1 field arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pfasm_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned ELEM_W  = 256;
   localparam int unsigned PROD_W  = 512;
   localparam int unsigned LIMB_W  = 32;
   localparam int unsigned LIMBS   = ELEM_W / LIMB_W;
   localparam int unsigned STAGES  = 9;
   localparam int unsigned ALT_DLY = 6;

   localparam logic [ELEM_W-1:0] PRIME_P =
      256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2F;
   localparam logic [ELEM_W-1:0] FOLD_K  = 256'h1000003D1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_NEG = 2'd3
   } op_type;

   typedef struct packed {
      op_type      req_type;
      logic [63:0] a_w0;
      logic [63:0] a_w1;
      logic [63:0] a_w2;
      logic [63:0] a_w3;
      logic [63:0] b_w0;
      logic [63:0] b_w1;
      logic [63:0] b_w2;
      logic [63:0] b_w3;
   } req_data_type;

   typedef struct packed {
      logic [63:0] r_w0;
      logic [63:0] r_w1;
      logic [63:0] r_w2;
      logic [63:0] r_w3;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: rtl/prime_field_add_sub_mul_top.sv
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds only while the response register is full and not taken.
// Reset clears the stage valid bits and the response valid; data is not reset.
// Longest stages are the 512-bit adder levels of the product tree.
// ----------------------------------------------------------------------------
// prime_field_add_sub_mul_top
// secp256k1 field unit: add, subtract, negate and multiply mod p.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_field_add_sub_mul_top import pfasm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_data_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_data_type      rsp_data
);

   logic              en;
   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES-1:0] mul_ff, mul_in;
   req_data_type      in_ff;
   logic [ELEM_W-1:0] a, b;
   logic [PROD_W-1:0] prod;
   logic [ELEM_W-1:0] mul_res;
   logic [ELEM_W-1:0] alt_res;
   logic [ELEM_W-1:0] alt_ff [ALT_DLY];
   logic              rsp_valid_ff;
   rsp_data_type      rsp_ff, rsp_in;
   logic [ELEM_W-1:0] fin;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign a = {in_ff.a_w3, in_ff.a_w2, in_ff.a_w1, in_ff.a_w0};
   assign b = {in_ff.b_w3, in_ff.b_w2, in_ff.b_w1, in_ff.b_w0};

   pfasm_mult u_mult (
      .clock (clock),
      .en    (en),
      .a     (a),
      .b     (b),
      .prod  (prod)
   );

   pfasm_reduce u_reduce (
      .clock (clock),
      .en    (en),
      .prod  (prod),
      .res   (mul_res)
   );

   pfasm_addsub u_addsub (
      .clock (clock),
      .en    (en),
      .op    (in_ff.req_type),
      .a     (a),
      .b     (b),
      .res   (alt_res)
   );

   always_comb begin
      vld_in = {vld_ff[STAGES-2:0], req_valid};
      mul_in = {mul_ff[STAGES-2:0], req_data.req_type == OP_MUL};
      fin    = mul_ff[STAGES-1] ? mul_res : alt_ff[ALT_DLY-1];
      rsp_in = {fin[63:0], fin[127:64], fin[191:128], fin[255:192]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff     <= req_data;
         mul_ff    <= mul_in;
         alt_ff[0] <= alt_res;
         for (int i = 1; i < ALT_DLY; i++) begin
            alt_ff[i] <= alt_ff[i-1];
         end
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_last_to_rsp : assert property (@(posedge clock) disable iff (reset)
      en |=> (rsp_valid_ff == $past(vld_ff[STAGES-1])))
      else $error("last stage beat lost or invented");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("stall with empty response register");

endmodule

`default_nettype wire

// File: rtl/pfasm_mult.sv
// ----------------------------------------------------------------------------
// pfasm_mult
// 256 x 256 product: one stage of 32 x 32 limb products, four adder levels.
// ----------------------------------------------------------------------------
`default_nettype none

module pfasm_mult import pfasm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [ELEM_W-1:0] a,
   input  wire logic [ELEM_W-1:0] b,
   output logic      [PROD_W-1:0] prod
);

   logic [2*LIMB_W-1:0] pp_ff [LIMBS][LIMBS];
   logic [2*LIMB_W-1:0] pp_in [LIMBS][LIMBS];
   logic [PROD_W-1:0]   row    [2*LIMBS];
   logic [PROD_W-1:0]   l1_ff  [LIMBS];
   logic [PROD_W-1:0]   l1_in  [LIMBS];
   logic [PROD_W-1:0]   l2_ff  [LIMBS/2];
   logic [PROD_W-1:0]   l2_in  [LIMBS/2];
   logic [PROD_W-1:0]   l3_ff  [LIMBS/4];
   logic [PROD_W-1:0]   l3_in  [LIMBS/4];
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;

   always_comb begin
      for (int i = 0; i < LIMBS; i++) begin
         for (int j = 0; j < LIMBS; j++) begin
            pp_in[i][j] = {{LIMB_W{1'b0}}, a[LIMB_W*i +: LIMB_W]}
                        * {{LIMB_W{1'b0}}, b[LIMB_W*j +: LIMB_W]};
         end
      end
      for (int i = 0; i < LIMBS; i++) begin
         row[2*i]   = '0;
         row[2*i+1] = '0;
         for (int j = 0; j < LIMBS; j++) begin
            if (j % 2 == 0) begin
               row[2*i][LIMB_W*(i+j) +: 2*LIMB_W] = pp_ff[i][j];
            end else begin
               row[2*i+1][LIMB_W*(i+j) +: 2*LIMB_W] = pp_ff[i][j];
            end
         end
      end
      for (int k = 0; k < LIMBS; k++) begin
         l1_in[k] = row[2*k] + row[2*k+1];
      end
      for (int k = 0; k < LIMBS/2; k++) begin
         l2_in[k] = l1_ff[2*k] + l1_ff[2*k+1];
      end
      for (int k = 0; k < LIMBS/4; k++) begin
         l3_in[k] = l2_ff[2*k] + l2_ff[2*k+1];
      end
      prod_in = l3_ff[0] + l3_ff[1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= pp_in;
         l1_ff   <= l1_in;
         l2_ff   <= l2_in;
         l3_ff   <= l3_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: rtl/pfasm_reduce.sv
// ----------------------------------------------------------------------------
// pfasm_reduce
// Fold a 512-bit product twice with 2^256 mod p = 2^32 + 977 and correct once.
// ----------------------------------------------------------------------------
`default_nettype none

module pfasm_reduce import pfasm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [PROD_W-1:0] prod,
   output logic      [ELEM_W-1:0] res
);

   localparam int unsigned HK_W  = ELEM_W + 10;
   localparam int unsigned S1_W  = ELEM_W + 34;
   localparam int unsigned TOP_W = S1_W - ELEM_W;

   logic [ELEM_W-1:0] lo_ff,  lo_in;
   logic [ELEM_W-1:0] hi_ff,  hi_in;
   logic [HK_W-1:0]   hk_ff,  hk_in;
   logic [S1_W-1:0]   s1_ff,  s1_in;
   logic [ELEM_W:0]   u_ff,   u_in;
   logic [TOP_W-1:0]  top;
   logic [TOP_W+9:0]  top977;
   logic [HK_W-1:0]   hw;

   always_comb begin
      lo_in  = prod[ELEM_W-1:0];
      hi_in  = prod[PROD_W-1:ELEM_W];
      hw     = {10'd0, hi_in};
      hk_in  = (hw << 10) + (hw << 4) + hw - (hw << 6);
      s1_in  = {{(S1_W-ELEM_W){1'b0}}, lo_ff}
             + {2'd0, hi_ff, 32'd0}
             + {{(S1_W-HK_W){1'b0}}, hk_ff};
      top    = s1_ff[S1_W-1:ELEM_W];
      top977 = {10'd0, top} * (TOP_W+10)'(977);
      u_in   = {1'b0, s1_ff[ELEM_W-1:0]}
             + {{(ELEM_W+1-TOP_W-32){1'b0}}, top, 32'd0}
             + {{(ELEM_W+1-TOP_W-10){1'b0}}, top977};
      res    = u_ff[ELEM_W] ? (u_ff[ELEM_W-1:0] + FOLD_K) : u_ff[ELEM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         hk_ff <= hk_in;
         s1_ff <= s1_in;
         u_ff  <= u_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pfasm_addsub.sv
// ----------------------------------------------------------------------------
// pfasm_addsub
// Modular add, subtract and negate in two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pfasm_addsub import pfasm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire op_type            op,
   input  wire logic [ELEM_W-1:0] a,
   input  wire logic [ELEM_W-1:0] b,
   output logic      [ELEM_W-1:0] res
);

   op_type            op_ff;
   logic [ELEM_W:0]   sum_ff, sum_in;
   logic [ELEM_W:0]   dif_ff, dif_in;
   logic [ELEM_W-1:0] neg_ff, neg_in;
   logic [ELEM_W-1:0] res_ff, res_in;
   logic              ge_p;

   always_comb begin
      sum_in = {1'b0, a} + {1'b0, b};
      dif_in = {1'b0, a} - {1'b0, b};
      neg_in = PRIME_P - a;
      ge_p   = sum_ff[ELEM_W] || (sum_ff[ELEM_W-1:0] >= PRIME_P);
      unique case (op_ff)
         OP_ADD:  res_in = ge_p ? (sum_ff[ELEM_W-1:0] + FOLD_K) : sum_ff[ELEM_W-1:0];
         OP_SUB:  res_in = dif_ff[ELEM_W] ? (dif_ff[ELEM_W-1:0] + PRIME_P)
                                          : dif_ff[ELEM_W-1:0];
         OP_NEG:  res_in = neg_ff;
         default: res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff  <= op;
         sum_ff <= sum_in;
         dif_ff <= dif_in;
         neg_ff <= neg_in;
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire
